/* rtl/henon_escape_time_core_macros.svh */
// Assertion macros of the checker file of the Henon escape-time core.
// No dependencies; take in with a bare include before use.
`ifndef HENON_ESCAPE_TIME_CORE_MACROS_SVH
`define HENON_ESCAPE_TIME_CORE_MACROS_SVH

// Clocked check, switched off while reset is asserted
`define HEN_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("henon core check failed");

// Clocked check that also runs through reset
`define HEN_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("henon core reset check failed");

`endif

/* rtl/hen_pkg.sv */
// Shared types and constants of the Henon escape-time core.
// No dependencies; used by every module of the core by scoped names.
package hen_pkg;

  // Fixed port widths
  localparam int unsigned FIELD_BITS = 32;
  localparam int unsigned STEP_BITS  = 16;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned RADIUS_SQ  = 100;
  localparam logic [STEP_BITS-1:0] MAX_ITER_RESET = 16'd500;

  // Input beat: pixel parameter t
  typedef struct packed {
    logic signed [FIELD_BITS-1:0] t_real;
    logic signed [FIELD_BITS-1:0] t_imag;
  } in_item_t;

  // Result beat
  typedef struct packed {
    logic                 escaped;
    logic [STEP_BITS-1:0] steps;
  } out_item_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_S_RE,
    REG_S_IM,
    REG_X0_RE,
    REG_X0_IM,
    REG_Y0_RE,
    REG_Y0_IM,
    REG_MAX_ITER
  } cfg_reg_t;

  // Operand sources of the shared multiplier
  typedef enum logic [2:0] {
    SRC_XR,
    SRC_XI,
    SRC_YR,
    SRC_YI,
    SRC_SR,
    SRC_SI
  } src_t;

  // Where a product goes once formed
  typedef struct packed {
    logic to_sum;  // add the exact square to the radius sum
    logic to_re;   // add the rounded term to the new real part
    logic to_im;   // add the rounded term to the new imaginary part
    logic sub;     // subtract from the new real part instead of add
    logic half_k;  // round to one fraction bit fewer (doubled term)
    logic last;    // final product of the step
  } op_tag_t;

  typedef struct packed {
    src_t    src_a;
    src_t    src_b;
    op_tag_t tag;
  } op_info_t;

  // Product stream control between the multiplier and the accumulator
  typedef struct packed {
    logic    valid;
    logic    neg;
    op_tag_t tag;
  } prod_ctl_t;

  localparam int unsigned NUM_OPS = 9;
  localparam int unsigned OP_BITS = 4;

  // Product schedule of one map step: four squares, then the cross terms
  function automatic op_info_t op_info(logic [OP_BITS-1:0] idx);
    op_info_t r;
    r = '0;
    r.src_a = SRC_XR;
    r.src_b = SRC_XR;
    case (idx)
      4'd0: begin
        r.src_a = SRC_XR; r.src_b = SRC_XR; r.tag.to_sum = 1'b1;
      end
      4'd1: begin
        r.src_a = SRC_XI; r.src_b = SRC_XI; r.tag.to_sum = 1'b1;
      end
      4'd2: begin
        r.src_a = SRC_YR; r.src_b = SRC_YR; r.tag.to_sum = 1'b1; r.tag.to_re = 1'b1;
      end
      4'd3: begin
        r.src_a = SRC_YI; r.src_b = SRC_YI; r.tag.to_sum = 1'b1; r.tag.to_re = 1'b1;
        r.tag.sub = 1'b1;
      end
      4'd4: begin
        r.src_a = SRC_SR; r.src_b = SRC_YR; r.tag.to_re = 1'b1;
      end
      4'd5: begin
        r.src_a = SRC_SI; r.src_b = SRC_YI; r.tag.to_re = 1'b1; r.tag.sub = 1'b1;
      end
      4'd6: begin
        r.src_a = SRC_YR; r.src_b = SRC_YI; r.tag.to_im = 1'b1; r.tag.half_k = 1'b1;
      end
      4'd7: begin
        r.src_a = SRC_SR; r.src_b = SRC_YI; r.tag.to_im = 1'b1;
      end
      4'd8: begin
        r.src_a = SRC_SI; r.src_b = SRC_YR; r.tag.to_im = 1'b1;
      end
      default: begin
        r.src_a = SRC_XR;
      end
    endcase
    return r;
  endfunction

endpackage

/* rtl/hen_mul.sv */
// Shared signed multiplier of the Henon core: magnitudes cut into limbs, one
// limb pair per cycle while issue is high, partial products summed into the exact product.
// Depends on hen_pkg.
module hen_mul #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned LIMBS     = 1,
  parameter int unsigned LIMB_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          issue,
  input  logic [WORD_BITS-1:0]          a,
  input  logic [WORD_BITS-1:0]          b,
  input  hen_pkg::op_tag_t              tag_in,
  output logic                          adv,
  output hen_pkg::prod_ctl_t            prod_ctl,
  output logic [2*LIMBS*LIMB_BITS-1:0]  prod_mag
);

  localparam int unsigned PADW = LIMBS * LIMB_BITS;
  localparam int unsigned PW   = 2 * PADW;
  localparam int unsigned LCW  = (LIMBS > 1) ? $clog2(LIMBS) : 1;
  localparam int unsigned SCW  = LCW + 1;
  localparam logic [LCW-1:0] LIMB_LAST = LCW'(LIMBS - 1);

  logic [LCW-1:0]        li_r, lj_r, li_nxt, lj_nxt;
  logic [WORD_BITS-1:0]  mag_a, mag_b;
  logic [PADW-1:0]       pad_a, pad_b;
  logic [LIMB_BITS-1:0]  limb_a, limb_b;
  logic                  first_pair, last_pair;

  // Stage A: selected limbs
  logic                  va_r, firsta_r, lasta_r, nega_r;
  logic [LIMB_BITS-1:0]  la_r, lb_r;
  logic [SCW-1:0]        sha_r;
  hen_pkg::op_tag_t      taga_r;

  // Stage B: partial product
  logic                  vb_r, firstb_r, lastb_r, negb_r;
  logic [2*LIMB_BITS-1:0] pp_r;
  logic [SCW-1:0]        shb_r;
  hen_pkg::op_tag_t      tagb_r;

  // Stage C: assembled product
  logic [PW-1:0]         acc_r;
  hen_pkg::prod_ctl_t    ctl_r;

  // Take magnitudes and pick the current limbs
  assign mag_a  = a[WORD_BITS-1] ? (~a + WORD_BITS'(1)) : a;
  assign mag_b  = b[WORD_BITS-1] ? (~b + WORD_BITS'(1)) : b;
  assign pad_a  = PADW'(mag_a);
  assign pad_b  = PADW'(mag_b);
  assign limb_a = pad_a[li_r*LIMB_BITS +: LIMB_BITS];
  assign limb_b = pad_b[lj_r*LIMB_BITS +: LIMB_BITS];

  assign first_pair = (li_r == '0) && (lj_r == '0);
  assign last_pair  = (li_r == LIMB_LAST) && (lj_r == LIMB_LAST);
  assign adv        = issue && last_pair;

  // Advance the limb pair counters
  always_comb begin
    li_nxt = li_r;
    lj_nxt = lj_r;
    if (issue) begin
      if (lj_r == LIMB_LAST) begin
        lj_nxt = '0;
        li_nxt = (li_r == LIMB_LAST) ? '0 : li_r + LCW'(1);
      end else begin
        lj_nxt = lj_r + LCW'(1);
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      li_r        <= '0;
      lj_r        <= '0;
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      ctl_r.valid <= 1'b0;
      ctl_r.neg   <= 1'b0;
      ctl_r.tag   <= '0;
    end else begin
      li_r        <= li_nxt;
      lj_r        <= lj_nxt;
      va_r        <= issue;
      vb_r        <= va_r;
      ctl_r.valid <= vb_r && lastb_r;
      ctl_r.neg   <= negb_r;
      ctl_r.tag   <= tagb_r;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    la_r      <= limb_a;
    lb_r      <= limb_b;
    sha_r     <= SCW'(li_r) + SCW'(lj_r);
    firsta_r  <= first_pair;
    lasta_r   <= last_pair;
    nega_r    <= a[WORD_BITS-1] ^ b[WORD_BITS-1];
    taga_r    <= tag_in;

    pp_r      <= la_r * lb_r;
    shb_r     <= sha_r;
    firstb_r  <= firsta_r;
    lastb_r   <= lasta_r;
    negb_r    <= nega_r;
    tagb_r    <= taga_r;

    // Sum the shifted partial product, restart on the first pair
    if (vb_r) begin
      acc_r <= (firstb_r ? '0 : acc_r) + (PW'(pp_r) << (shb_r * LIMB_BITS));
    end
  end

  assign prod_ctl = ctl_r;
  assign prod_mag = acc_r;

endmodule

/* rtl/hen_acc.sv */
// Rounding and accumulation of the Henon core: rounds each product, sums the
// new orbit coordinates and the radius test, saturates to the word range.
// Depends on hen_pkg.
module hen_acc #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 22,
  parameter int unsigned PROD_BITS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  init,
  input  logic [WORD_BITS-1:0]  x_re,
  input  logic [WORD_BITS-1:0]  x_im,
  input  logic [WORD_BITS-1:0]  t_re,
  input  logic [WORD_BITS-1:0]  t_im,
  input  hen_pkg::prod_ctl_t    prod_ctl,
  input  logic [PROD_BITS-1:0]  prod_mag,
  output logic                  fin,
  output logic [PROD_BITS+1:0]  sum,
  output logic [WORD_BITS-1:0]  new_re,
  output logic [WORD_BITS-1:0]  new_im
);

  localparam int unsigned TW = (PROD_BITS + 1 > FRAC_BITS + 1) ? PROD_BITS + 1 : FRAC_BITS + 1;
  localparam int unsigned AW = TW + 3;
  localparam int unsigned SW = PROD_BITS + 2;
  localparam logic [TW-1:0] HALF_HI = TW'(1) << (FRAC_BITS - 1);
  localparam logic [TW-1:0] HALF_LO = TW'(1) << (FRAC_BITS - 2);

  logic [TW-1:0]         half_v;
  logic signed [TW-1:0]  flip, rnd, term;

  logic                  rv_r, fin_r;
  hen_pkg::op_tag_t      rtag_r;
  logic signed [TW-1:0]  term_r;
  logic [PROD_BITS-1:0]  sq_r;

  logic [SW-1:0]         sum_r;
  logic signed [AW-1:0]  re_r, im_r;

  // Clamp an accumulator to the signed word range
  function automatic logic [WORD_BITS-1:0] sat(logic signed [AW-1:0] v);
    logic [WORD_BITS-1:0] r;
    if ((&v[AW-1:WORD_BITS-1]) || !(|v[AW-1:WORD_BITS-1])) begin
      r = v[WORD_BITS-1:0];
    end else if (v[AW-1]) begin
      r = {1'b1, {(WORD_BITS-1){1'b0}}};
    end else begin
      r = {1'b0, {(WORD_BITS-1){1'b1}}};
    end
    return r;
  endfunction

  // Apply the sign and round to nearest, ties up, in one add
  assign flip   = $signed(TW'(prod_mag) ^ {TW{prod_ctl.neg}});
  assign half_v = (prod_ctl.tag.half_k ? HALF_LO : HALF_HI) | TW'(prod_ctl.neg);
  assign rnd    = flip + $signed(half_v);
  assign term   = prod_ctl.tag.half_k ? (rnd >>> (FRAC_BITS - 1)) : (rnd >>> FRAC_BITS);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv_r  <= 1'b0;
      fin_r <= 1'b0;
    end else begin
      rv_r  <= prod_ctl.valid;
      fin_r <= rv_r && rtag_r.last;
    end
  end

  // Rounded term, then the running sums
  always_ff @(posedge clk) begin
    rtag_r <= prod_ctl.tag;
    term_r <= term;
    sq_r   <= prod_mag;
    if (init) begin
      sum_r <= '0;
      re_r  <= AW'($signed(x_re)) + AW'($signed(t_re));
      im_r  <= AW'($signed(x_im)) + AW'($signed(t_im));
    end else if (rv_r) begin
      if (rtag_r.to_sum) begin
        sum_r <= sum_r + SW'(sq_r);
      end
      if (rtag_r.to_re) begin
        re_r <= rtag_r.sub ? (re_r - AW'(term_r)) : (re_r + AW'(term_r));
      end
      if (rtag_r.to_im) begin
        im_r <= im_r + AW'(term_r);
      end
    end
  end

  assign fin    = fin_r;
  assign sum    = sum_r;
  assign new_re = sat(re_r);
  assign new_im = sat(im_r);

endmodule

/* rtl/henon_escape_time_core.sv */
// Top level of the Henon escape-time core: configuration registers, orbit
// state and step sequencer around the shared multiplier and accumulator.
// Depends on hen_pkg, hen_mul and hen_acc.
//
//  channel | ports                          | handshake
//  --------+--------------------------------+-------------------------------
//  input   | start, busy, in_data           | beat taken when start && !busy
//  result  | out_strobe, out_data           | one-cycle strobe, no back-pressure
//  config  | cfg_valid, cfg_ready, cfg_index, | write when cfg_valid && cfg_ready
//          | cfg_data                       |
//
// A map step runs nine products through the single multiplier, one limb
// pair a cycle, L = ceil(WORD_BITS/32) limbs, then the pipeline drain and
// the limit check.
// busy stays high from the accepted beat until the result strobe.
// Reset is synchronous; configuration writes are taken in any cycle.
module henon_escape_time_core #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned FRAC_BITS = 22
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  hen_pkg::in_item_t                   in_data,
  output logic                                out_strobe,
  output hen_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hen_pkg::CFG_IDX_BITS-1:0]    cfg_index,
  input  logic [hen_pkg::FIELD_BITS-1:0]      cfg_data
);

  localparam int unsigned W     = WORD_BITS;
  localparam int unsigned LIMBS = (W + 31) / 32;
  localparam int unsigned LB    = (W + LIMBS - 1) / LIMBS;
  localparam int unsigned PW    = 2 * LIMBS * LB;
  localparam int unsigned SW    = PW + 2;
  localparam int unsigned LW    = 2 * FRAC_BITS + 8;
  localparam int unsigned CW    = (SW > LW) ? SW : LW;
  localparam int unsigned XW    = (W > hen_pkg::FIELD_BITS) ? W : hen_pkg::FIELD_BITS;
  localparam logic [CW-1:0] RADIUS_LIM = CW'(hen_pkg::RADIUS_SQ) << (2 * FRAC_BITS);
  localparam logic [hen_pkg::OP_BITS-1:0] OP_LAST = hen_pkg::OP_BITS'(hen_pkg::NUM_OPS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_ISSUE,
    ST_DRAIN
  } state_t;

  // Configuration
  logic [W-1:0]                    s_re_r, s_im_r, x0_re_r, x0_im_r, y0_re_r, y0_im_r;
  logic [hen_pkg::STEP_BITS-1:0]   max_iter_r;

  // Sequencer and orbit state
  state_t                          state_r, state_nxt;
  logic [hen_pkg::OP_BITS-1:0]     op_r, op_nxt;
  logic [hen_pkg::STEP_BITS-1:0]   count_r, count_nxt;
  logic [W-1:0]                    xr_r, xi_r, yr_r, yi_r, xr_nxt, xi_nxt, yr_nxt, yi_nxt;
  logic [W-1:0]                    t_re_r, t_im_r, t_re_nxt, t_im_nxt;
  logic                            out_strobe_r, out_strobe_nxt;
  hen_pkg::out_item_t              out_data_r, out_data_nxt;
  logic                            acc_init;

  // Shared unit wiring
  hen_pkg::op_info_t               info;
  hen_pkg::op_tag_t                tag;
  logic [W-1:0]                    opa, opb;
  logic                            issue, adv, fin;
  hen_pkg::prod_ctl_t              prod_ctl;
  logic [PW-1:0]                   prod_mag;
  logic [SW-1:0]                   sum;
  logic [W-1:0]                    new_re, new_im;

  // Sign-extend a 32-bit field and clamp it to the word range
  function automatic logic [W-1:0] load_word(logic [hen_pkg::FIELD_BITS-1:0] v);
    logic signed [XW-1:0] e;
    logic [W-1:0]         r;
    e = XW'($signed(v));
    if ((&e[XW-1:W-1]) || !(|e[XW-1:W-1])) begin
      r = e[W-1:0];
    end else if (e[XW-1]) begin
      r = {1'b1, {(W-1){1'b0}}};
    end else begin
      r = {1'b0, {(W-1){1'b1}}};
    end
    return r;
  endfunction

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_re_r     <= '0;
      s_im_r     <= '0;
      x0_re_r    <= '0;
      x0_im_r    <= '0;
      y0_re_r    <= '0;
      y0_im_r    <= '0;
      max_iter_r <= hen_pkg::MAX_ITER_RESET;
    end else if (cfg_valid) begin
      unique case (hen_pkg::cfg_reg_t'(cfg_index))
        hen_pkg::REG_S_RE:     s_re_r     <= load_word(cfg_data);
        hen_pkg::REG_S_IM:     s_im_r     <= load_word(cfg_data);
        hen_pkg::REG_X0_RE:    x0_re_r    <= load_word(cfg_data);
        hen_pkg::REG_X0_IM:    x0_im_r    <= load_word(cfg_data);
        hen_pkg::REG_Y0_RE:    y0_re_r    <= load_word(cfg_data);
        hen_pkg::REG_Y0_IM:    y0_im_r    <= load_word(cfg_data);
        hen_pkg::REG_MAX_ITER: max_iter_r <= cfg_data[hen_pkg::STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pick the operands of the current product
  assign info = hen_pkg::op_info(op_r);

  always_comb begin
    tag      = info.tag;
    tag.last = (op_r == OP_LAST);
    case (info.src_a)
      hen_pkg::SRC_XR: opa = xr_r;
      hen_pkg::SRC_XI: opa = xi_r;
      hen_pkg::SRC_YR: opa = yr_r;
      hen_pkg::SRC_YI: opa = yi_r;
      hen_pkg::SRC_SR: opa = s_re_r;
      hen_pkg::SRC_SI: opa = s_im_r;
      default:         opa = '0;
    endcase
    case (info.src_b)
      hen_pkg::SRC_XR: opb = xr_r;
      hen_pkg::SRC_XI: opb = xi_r;
      hen_pkg::SRC_YR: opb = yr_r;
      hen_pkg::SRC_YI: opb = yi_r;
      hen_pkg::SRC_SR: opb = s_re_r;
      hen_pkg::SRC_SI: opb = s_im_r;
      default:         opb = '0;
    endcase
  end

  assign issue = (state_r == ST_ISSUE);

  hen_mul #(
    .WORD_BITS (W),
    .LIMBS     (LIMBS),
    .LIMB_BITS (LB)
  ) u_mul (
    .clk      (clk),
    .rst_n    (rst_n),
    .issue    (issue),
    .a        (opa),
    .b        (opb),
    .tag_in   (tag),
    .adv      (adv),
    .prod_ctl (prod_ctl),
    .prod_mag (prod_mag)
  );

  hen_acc #(
    .WORD_BITS (W),
    .FRAC_BITS (FRAC_BITS),
    .PROD_BITS (PW)
  ) u_acc (
    .clk      (clk),
    .rst_n    (rst_n),
    .init     (acc_init),
    .x_re     (xr_r),
    .x_im     (xi_r),
    .t_re     (t_re_r),
    .t_im     (t_im_r),
    .prod_ctl (prod_ctl),
    .prod_mag (prod_mag),
    .fin      (fin),
    .sum      (sum),
    .new_re   (new_re),
    .new_im   (new_im)
  );

  // Step sequencer
  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    count_nxt      = count_r;
    xr_nxt         = xr_r;
    xi_nxt         = xi_r;
    yr_nxt         = yr_r;
    yi_nxt         = yi_r;
    t_re_nxt       = t_re_r;
    t_im_nxt       = t_im_r;
    out_strobe_nxt = 1'b0;
    out_data_nxt   = out_data_r;
    acc_init       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        // Take the pixel beat and load the start point
        if (start) begin
          t_re_nxt  = load_word(in_data.t_real);
          t_im_nxt  = load_word(in_data.t_imag);
          xr_nxt    = x0_re_r;
          xi_nxt    = x0_im_r;
          yr_nxt    = y0_re_r;
          yi_nxt    = y0_im_r;
          count_nxt = '0;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // Stop at the limit, otherwise start the products of a step
        if (count_r == max_iter_r) begin
          out_strobe_nxt       = 1'b1;
          out_data_nxt.escaped = 1'b0;
          out_data_nxt.steps   = '0;
          state_nxt            = ST_IDLE;
        end else begin
          acc_init  = 1'b1;
          op_nxt    = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (adv) begin
          if (op_r == OP_LAST) begin
            state_nxt = ST_DRAIN;
          end else begin
            op_nxt = op_r + hen_pkg::OP_BITS'(1);
          end
        end
      end
      ST_DRAIN: begin
        // Radius test on the old point decides; else commit the new point
        if (fin) begin
          if (!(CW'(sum) < RADIUS_LIM)) begin
            out_strobe_nxt       = 1'b1;
            out_data_nxt.escaped = 1'b1;
            out_data_nxt.steps   = count_r;
            state_nxt            = ST_IDLE;
          end else begin
            xr_nxt    = yr_r;
            xi_nxt    = yi_r;
            yr_nxt    = new_re;
            yi_nxt    = new_im;
            count_nxt = count_r + hen_pkg::STEP_BITS'(1);
            state_nxt = ST_CHECK;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      op_r         <= '0;
      count_r      <= '0;
      xr_r         <= '0;
      xi_r         <= '0;
      yr_r         <= '0;
      yi_r         <= '0;
      out_strobe_r <= 1'b0;
      out_data_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      op_r         <= op_nxt;
      count_r      <= count_nxt;
      xr_r         <= xr_nxt;
      xi_r         <= xi_nxt;
      yr_r         <= yr_nxt;
      yi_r         <= yi_nxt;
      t_re_r       <= t_re_nxt;
      t_im_r       <= t_im_nxt;
      out_strobe_r <= out_strobe_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign busy       = (state_r != ST_IDLE);
  assign out_strobe = out_strobe_r;
  assign out_data   = out_data_r;

endmodule

/* rtl/hen_chk.sv */
// Port-level checks of the Henon escape-time core and their binding.
// Depends on hen_pkg, henon_escape_time_core_macros.svh and the top level.
`include "henon_escape_time_core_macros.svh"

module hen_chk (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_strobe,
  input hen_pkg::out_item_t out_data
);

  // A result beat only appears once the core is free again
  `HEN_ASSERT(a_strobe_idle, clk, rst_n, out_strobe |-> !busy)

  // An accepted beat makes the core busy
  `HEN_ASSERT(a_start_busy, clk, rst_n, start && !busy |=> busy)

  // Every finished pixel delivers its result as busy drops
  `HEN_ASSERT(a_fall_result, clk, rst_n, $fell(busy) && $past(rst_n) |-> out_strobe)

  // A bounded orbit reports no step count
  `HEN_ASSERT(a_bounded_zero, clk, rst_n, out_strobe && !out_data.escaped |-> out_data.steps == 16'd0)

  // Reset drops the strobe and the busy flag
  `HEN_ASSERT_RST(a_reset_quiet, clk, !rst_n |=> !out_strobe && !busy)

endmodule

bind henon_escape_time_core hen_chk u_hen_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);
